### rtl/core/lrutsp_pkg.sv
package lrutsp_pkg;

  localparam int OP_W    = 3;
  localparam int ENTRY_W = 6;
  localparam int SLOT_W  = 5;
  localparam int TS_W    = 32;

  // Entry indices reachable through the fixed-width entry port
  localparam int ENTRY_SPACE = 2 ** ENTRY_W;

  typedef logic [OP_W-1:0]    op_t;
  typedef logic [ENTRY_W-1:0] entry_t;
  typedef logic [SLOT_W-1:0]  slot_num_t;
  typedef logic [TS_W-1:0]    ts_t;

  localparam op_t OP_NEW_FRAME = 3'd0;
  localparam op_t OP_LOOKUP    = 3'd1;
  localparam op_t OP_ALLOC     = 3'd2;
  localparam op_t OP_RESOLVE   = 3'd3;
  localparam op_t OP_CLEAR     = 3'd4;

  typedef struct packed {
    entry_t owner;
    ts_t    last_used;
    logic   done;
  } slot_ent_t;

endpackage

### rtl/core/lrutsp_slot_mem.sv
module lrutsp_slot_mem #(
  parameter int NUM_SLOTS = 25,
  parameter int AW        = 5
) (
  input  logic                  clk,
  input  logic [AW-1:0]         rd_addr,
  output lrutsp_pkg::slot_ent_t rd_data,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  lrutsp_pkg::slot_ent_t wr_data
);

  lrutsp_pkg::slot_ent_t mem_r [NUM_SLOTS];
  lrutsp_pkg::slot_ent_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/lrutsp_map_mem.sv
module lrutsp_map_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  clr,
  input  logic [AW-1:0]         rd_addr,
  output lrutsp_pkg::slot_num_t rd_data,
  output logic                  rd_vld,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  lrutsp_pkg::slot_num_t wr_data,
  input  logic                  inv_en,
  input  logic [AW-1:0]         inv_addr
);

  lrutsp_pkg::slot_num_t mem_r [DEPTH];
  lrutsp_pkg::slot_num_t rd_data_r;
  logic [DEPTH-1:0]      vld_r;
  logic                  rd_vld_r;

  // Valid bits live in flops so that clear-all takes effect at once
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r <= '0;
    end else begin
      if (inv_en) begin
        vld_r[inv_addr] <= 1'b0;
      end
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
    rd_vld_r  <= vld_r[rd_addr];
  end

  assign rd_data = rd_data_r;
  assign rd_vld  = rd_vld_r;

endmodule

### rtl/core/lru_thumbnail_slot_pool.sv
// LRU slot pool: maps up to NUM_ENTRIES entry indices onto NUM_SLOTS cache
// slots, with timestamp based replacement driven by a 32-bit frame counter.
// Command channel: an item (in_op, in_entry_idx) is taken at the clock edge
// where start is high and busy is low. busy stays high while the item runs.
// Result channel: out_valid strobes for exactly one cycle with the result
// fields; the receiver cannot stall, so each result must be taken then.
// Path after the accepting edge, ahead of the registered result strobe:
//   new frame, clear all, misses, unknown ops: map state only
//   hits, mark resolved: map, then hit; allocation into a free slot: map, then alloc
//   allocation with eviction: map, scan over every slot, then alloc
// The next item may be started in the strobe cycle. The eviction time comes
// from walking every slot timestamp through the single read port of the
// slot memory, one slot per cycle, to find the oldest. Free slots always
// form a prefix of the pool, so a fill count finds the lowest free slot.
// Reset (rst_n low, synchronous) and clear all empty the pool and the entry
// map and zero the frame counter.
module lru_thumbnail_slot_pool #(
  parameter int NUM_SLOTS   = 25,
  parameter int NUM_ENTRIES = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  lrutsp_pkg::op_t            in_op,
  input  lrutsp_pkg::entry_t         in_entry_idx,
  output logic                       out_valid,
  output logic                       out_found,
  output logic                       out_hit,
  output lrutsp_pkg::slot_num_t      out_slot,
  output logic                       out_slot_resolved,
  output logic                       out_evicted,
  output lrutsp_pkg::entry_t         out_evicted_entry
);

  localparam int MAP_DEPTH = (NUM_ENTRIES < lrutsp_pkg::ENTRY_SPACE) ?
                             NUM_ENTRIES : lrutsp_pkg::ENTRY_SPACE;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam int SLOT_AW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int FILL_W    = $clog2(NUM_SLOTS + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MAP   = 3'd1;
  localparam logic [2:0] ST_HIT   = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_ALLOC = 3'd4;

  logic [2:0]         state_r, state_nxt;
  lrutsp_pkg::op_t    op_r, op_nxt;
  lrutsp_pkg::entry_t ei_r, ei_nxt;
  lrutsp_pkg::ts_t    frame_r, frame_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [SLOT_AW-1:0] best_idx_r, best_idx_nxt;
  lrutsp_pkg::ts_t    best_ts_r, best_ts_nxt;
  lrutsp_pkg::entry_t best_owner_r, best_owner_nxt;
  logic               ev_r, ev_nxt;
  logic [SLOT_AW-1:0] scan_idx_r, scan_idx_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  found_r, found_nxt;
  logic                  hit_r, hit_nxt;
  lrutsp_pkg::slot_num_t slot_r, slot_nxt;
  logic                  res_r, res_nxt;
  logic                  evd_r, evd_nxt;
  lrutsp_pkg::entry_t    eve_r, eve_nxt;

  lrutsp_pkg::slot_num_t map_rd_data;
  logic                  map_rd_vld;
  logic                  map_wr_en;
  logic                  map_inv_en;
  logic                  map_clr;

  logic [SLOT_AW-1:0]    slot_rd_addr;
  lrutsp_pkg::slot_ent_t slot_rd_data;
  logic                  slot_wr_en;
  logic [SLOT_AW-1:0]    slot_wr_addr;
  lrutsp_pkg::slot_ent_t slot_wr_data;

  logic               accept;
  logic               in_range;
  logic               mapped;
  logic [SLOT_AW-1:0] map_slot;
  logic               scan_last;

  assign accept    = start && (state_r == ST_IDLE);
  assign in_range  = 32'(ei_r) < NUM_ENTRIES;
  assign mapped    = in_range && map_rd_vld;
  assign map_slot  = map_rd_data[SLOT_AW-1:0];
  assign scan_last = 32'(scan_idx_r) == (NUM_SLOTS - 1);

  lrutsp_map_mem #(
    .DEPTH (MAP_DEPTH),
    .AW    (MAP_AW)
  ) u_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (map_clr),
    .rd_addr  (in_entry_idx[MAP_AW-1:0]),
    .rd_data  (map_rd_data),
    .rd_vld   (map_rd_vld),
    .wr_en    (map_wr_en),
    .wr_addr  (ei_r[MAP_AW-1:0]),
    .wr_data  (lrutsp_pkg::slot_num_t'(best_idx_r)),
    .inv_en   (map_inv_en),
    .inv_addr (best_owner_r[MAP_AW-1:0])
  );

  lrutsp_slot_mem #(
    .NUM_SLOTS (NUM_SLOTS),
    .AW        (SLOT_AW)
  ) u_slots (
    .clk     (clk),
    .rd_addr (slot_rd_addr),
    .rd_data (slot_rd_data),
    .wr_en   (slot_wr_en),
    .wr_addr (slot_wr_addr),
    .wr_data (slot_wr_data)
  );

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    ei_nxt         = ei_r;
    frame_nxt      = frame_r;
    fill_nxt       = fill_r;
    best_idx_nxt   = best_idx_r;
    best_ts_nxt    = best_ts_r;
    best_owner_nxt = best_owner_r;
    ev_nxt         = ev_r;
    scan_idx_nxt   = scan_idx_r;

    out_valid_nxt = 1'b0;
    found_nxt     = found_r;
    hit_nxt       = hit_r;
    slot_nxt      = slot_r;
    res_nxt       = res_r;
    evd_nxt       = evd_r;
    eve_nxt       = eve_r;

    map_wr_en    = 1'b0;
    map_inv_en   = 1'b0;
    map_clr      = 1'b0;
    slot_rd_addr = '0;
    slot_wr_en   = 1'b0;
    slot_wr_addr = best_idx_r;
    slot_wr_data = slot_rd_data;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt    = in_op;
          ei_nxt    = in_entry_idx;
          state_nxt = ST_MAP;
        end
      end

      ST_MAP: begin
        // default result is all zeros; overwritten by the later states
        found_nxt = 1'b0;
        hit_nxt   = 1'b0;
        slot_nxt  = '0;
        res_nxt   = 1'b0;
        evd_nxt   = 1'b0;
        eve_nxt   = '0;
        state_nxt = ST_IDLE;
        case (op_r)
          lrutsp_pkg::OP_NEW_FRAME: begin
            frame_nxt     = frame_r + 1'b1;
            out_valid_nxt = 1'b1;
          end
          lrutsp_pkg::OP_CLEAR: begin
            frame_nxt     = '0;
            fill_nxt      = '0;
            map_clr       = 1'b1;
            out_valid_nxt = 1'b1;
          end
          lrutsp_pkg::OP_LOOKUP, lrutsp_pkg::OP_ALLOC, lrutsp_pkg::OP_RESOLVE: begin
            if (mapped) begin
              slot_rd_addr = map_slot;
              best_idx_nxt = map_slot;
              state_nxt    = ST_HIT;
            end else if (op_r == lrutsp_pkg::OP_ALLOC && in_range) begin
              if (32'(fill_r) < NUM_SLOTS) begin
                best_idx_nxt = fill_r[SLOT_AW-1:0];
                ev_nxt       = 1'b0;
                state_nxt    = ST_ALLOC;
              end else begin
                // pool full: walk all slots from slot 0
                slot_rd_addr = '0;
                scan_idx_nxt = '0;
                ev_nxt       = 1'b1;
                state_nxt    = ST_SCAN;
              end
            end else begin
              out_valid_nxt = 1'b1;
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
          end
        endcase
      end

      ST_HIT: begin
        slot_wr_en = 1'b1;
        found_nxt  = 1'b1;
        hit_nxt    = 1'b1;
        slot_nxt   = lrutsp_pkg::slot_num_t'(best_idx_r);
        if (op_r == lrutsp_pkg::OP_RESOLVE) begin
          slot_wr_data.done = 1'b1;
          res_nxt           = 1'b1;
        end else begin
          slot_wr_data.last_used = frame_r;
          res_nxt                = slot_rd_data.done;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end

      ST_SCAN: begin
        // read data belongs to scan_idx_r; strict compare keeps the lower index on ties
        if (scan_idx_r == '0 || slot_rd_data.last_used < best_ts_r) begin
          best_idx_nxt   = scan_idx_r;
          best_ts_nxt    = slot_rd_data.last_used;
          best_owner_nxt = slot_rd_data.owner;
        end
        if (scan_last) begin
          state_nxt = ST_ALLOC;
        end else begin
          slot_rd_addr = scan_idx_r + 1'b1;
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end

      ST_ALLOC: begin
        slot_wr_en             = 1'b1;
        slot_wr_data.owner     = ei_r;
        slot_wr_data.last_used = frame_r;
        slot_wr_data.done      = 1'b0;
        map_wr_en              = 1'b1;
        map_inv_en             = ev_r;
        if (!ev_r) begin
          fill_nxt = fill_r + 1'b1;
        end
        found_nxt     = 1'b1;
        hit_nxt       = 1'b0;
        slot_nxt      = lrutsp_pkg::slot_num_t'(best_idx_r);
        res_nxt       = 1'b0;
        evd_nxt       = ev_r;
        eve_nxt       = ev_r ? best_owner_r : '0;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      frame_r     <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      frame_r     <= frame_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    ei_r         <= ei_nxt;
    best_idx_r   <= best_idx_nxt;
    best_ts_r    <= best_ts_nxt;
    best_owner_r <= best_owner_nxt;
    ev_r         <= ev_nxt;
    scan_idx_r   <= scan_idx_nxt;
    found_r      <= found_nxt;
    hit_r        <= hit_nxt;
    slot_r       <= slot_nxt;
    res_r        <= res_nxt;
    evd_r        <= evd_nxt;
    eve_r        <= eve_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_found         = found_r;
  assign out_hit           = hit_r;
  assign out_slot          = slot_r;
  assign out_slot_resolved = res_r;
  assign out_evicted       = evd_r;
  assign out_evicted_entry = eve_r;

endmodule

### test/lru_thumbnail_slot_pool_check.sv
`timescale 1ns / 1ps

module lru_thumbnail_slot_pool_check #(
  parameter int NUM_SLOTS   = 25,
  parameter int NUM_ENTRIES = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  lrutsp_pkg::op_t       in_op,
  input  lrutsp_pkg::entry_t    in_entry_idx,
  input  logic                  out_valid,
  input  logic                  out_found,
  input  logic                  out_hit,
  input  lrutsp_pkg::slot_num_t out_slot,
  input  logic                  out_slot_resolved,
  input  logic                  out_evicted,
  input  lrutsp_pkg::entry_t    out_evicted_entry,
  output int                    fail_count,
  output int                    pending,
  output int                    checked,
  output int                    hits,
  output int                    evictions
);

  typedef struct packed {
    logic                  found;
    logic                  hit;
    lrutsp_pkg::slot_num_t slot;
    logic                  resolved;
    logic                  evicted;
    lrutsp_pkg::entry_t    ev_entry;
  } pool_res_t;

  // Shadow copy of the pool
  logic                  own_vld  [NUM_SLOTS];
  lrutsp_pkg::entry_t    own_ent  [NUM_SLOTS];
  lrutsp_pkg::ts_t       used_at  [NUM_SLOTS];
  logic                  marked   [NUM_SLOTS];
  logic                  map_vld  [lrutsp_pkg::ENTRY_SPACE];
  lrutsp_pkg::slot_num_t map_slot [lrutsp_pkg::ENTRY_SPACE];
  lrutsp_pkg::ts_t       frame_no;

  pool_res_t due_results[$];
  int        fails;
  int        n_checked;
  int        n_hits;
  int        n_evicted;

  function automatic void pool_clear();
    int i;
    for (i = 0; i < NUM_SLOTS; i++) begin
      own_vld[i] = 1'b0;
      own_ent[i] = '0;
      used_at[i] = '0;
      marked[i]  = 1'b0;
    end
    for (i = 0; i < lrutsp_pkg::ENTRY_SPACE; i++) begin
      map_vld[i]  = 1'b0;
      map_slot[i] = '0;
    end
    frame_no = '0;
  endfunction

  function automatic pool_res_t pool_apply(lrutsp_pkg::op_t op, lrutsp_pkg::entry_t idx);
    pool_res_t             r;
    logic                  mapped;
    logic                  in_range;
    lrutsp_pkg::slot_num_t s;
    int                    pick;
    int                    i;
    r        = '0;
    s        = map_slot[idx];
    in_range = int'(idx) < NUM_ENTRIES;
    mapped   = in_range && map_vld[idx] && (int'(s) < NUM_SLOTS);
    case (op)
      lrutsp_pkg::OP_NEW_FRAME: frame_no = frame_no + 1'b1;
      lrutsp_pkg::OP_LOOKUP, lrutsp_pkg::OP_ALLOC: begin
        if (mapped) begin
          used_at[s] = frame_no;
          r.found    = 1'b1;
          r.hit      = 1'b1;
          r.slot     = s;
          r.resolved = marked[s];
        end else if (op == lrutsp_pkg::OP_ALLOC && in_range) begin
          pick = -1;
          for (i = 0; i < NUM_SLOTS; i++)
            if (pick < 0 && !own_vld[i]) pick = i;
          if (pick < 0) begin
            // oldest wins, strictly smaller only, so the lower slot keeps ties
            pick = 0;
            for (i = 1; i < NUM_SLOTS; i++)
              if (used_at[i] < used_at[pick]) pick = i;
            r.evicted  = 1'b1;
            r.ev_entry = own_ent[pick];
            if (int'(own_ent[pick]) < NUM_ENTRIES) map_vld[own_ent[pick]] = 1'b0;
          end
          own_vld[pick]  = 1'b1;
          own_ent[pick]  = idx;
          used_at[pick]  = frame_no;
          marked[pick]   = 1'b0;
          map_vld[idx]   = 1'b1;
          map_slot[idx]  = lrutsp_pkg::slot_num_t'(pick);
          r.found        = 1'b1;
          r.slot         = lrutsp_pkg::slot_num_t'(pick);
        end
      end
      lrutsp_pkg::OP_RESOLVE: begin
        if (mapped) begin
          marked[s]  = 1'b1;
          r.found    = 1'b1;
          r.hit      = 1'b1;
          r.slot     = s;
          r.resolved = 1'b1;
        end
      end
      lrutsp_pkg::OP_CLEAR: pool_clear();
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    pool_res_t want;
    pool_res_t got;
    if (!rst_n) begin
      pool_clear();
      due_results.delete();
      fails     = 0;
      n_checked = 0;
      n_hits    = 0;
      n_evicted = 0;
    end else begin
      // retire the result beat before taking a new command in the same edge
      if (out_valid) begin
        got = '{out_found, out_hit, out_slot, out_slot_resolved, out_evicted,
                out_evicted_entry};
        if (due_results.size() == 0) begin
          if (fails < 10)
            $display("%0t: result beat with nothing outstanding: found=%0b hit=%0b slot=%0d",
                     $realtime, got.found, got.hit, got.slot);
          fails++;
        end else begin
          want = due_results.pop_front();
          n_checked++;
          if (want.hit) n_hits++;
          if (want.evicted) n_evicted++;
          if (got != want) begin
            if (fails < 10)
              $display({"%0t: mismatch exp found=%0b hit=%0b slot=%0d res=%0b ev=%0b ",
                        "ev_entry=%0d, got found=%0b hit=%0b slot=%0d res=%0b ev=%0b ",
                        "ev_entry=%0d"},
                       $realtime, want.found, want.hit, want.slot, want.resolved,
                       want.evicted, want.ev_entry, got.found, got.hit, got.slot,
                       got.resolved, got.evicted, got.ev_entry);
            fails++;
          end
        end
      end
      if (start && !busy) due_results.push_back(pool_apply(in_op, in_entry_idx));
    end
    fail_count <= fails;
    pending    <= due_results.size();
    checked    <= n_checked;
    hits       <= n_hits;
    evictions  <= n_evicted;
  end

endmodule

### test/lru_thumbnail_slot_pool_test.sv
`timescale 1ns / 1ps

module lru_thumbnail_slot_pool_test;

  localparam int NUM_SLOTS   = 25;
  localparam int NUM_ENTRIES = 64;
  localparam int STALL_LIMIT = 1000;
  localparam int PHASE_ITEMS = 600;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  lrutsp_pkg::op_t       in_op = lrutsp_pkg::OP_NEW_FRAME;
  lrutsp_pkg::entry_t    in_entry_idx = '0;
  logic                  busy;
  logic                  out_valid;
  logic                  out_found;
  logic                  out_hit;
  lrutsp_pkg::slot_num_t out_slot;
  logic                  out_slot_resolved;
  logic                  out_evicted;
  lrutsp_pkg::entry_t    out_evicted_entry;

  int fail_count;
  int pending;
  int checked;
  int hits;
  int evictions;
  int sent = 0;
  int idle_pct = 0;
  int quiet_cycles = 0;

  always #4 clk = ~clk;

  lru_thumbnail_slot_pool #(
    .NUM_SLOTS   (NUM_SLOTS),
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_entry_idx      (in_entry_idx),
    .out_valid         (out_valid),
    .out_found         (out_found),
    .out_hit           (out_hit),
    .out_slot          (out_slot),
    .out_slot_resolved (out_slot_resolved),
    .out_evicted       (out_evicted),
    .out_evicted_entry (out_evicted_entry)
  );

  lru_thumbnail_slot_pool_check #(
    .NUM_SLOTS   (NUM_SLOTS),
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_entry_idx      (in_entry_idx),
    .out_valid         (out_valid),
    .out_found         (out_found),
    .out_hit           (out_hit),
    .out_slot          (out_slot),
    .out_slot_resolved (out_slot_resolved),
    .out_evicted       (out_evicted),
    .out_evicted_entry (out_evicted_entry),
    .fail_count        (fail_count),
    .pending           (pending),
    .checked           (checked),
    .hits              (hits),
    .evictions         (evictions)
  );

  // Abort when neither channel moves a beat for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Called at a clock edge; returns at the edge that takes the command
  task automatic issue(lrutsp_pkg::op_t op, lrutsp_pkg::entry_t idx);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_op        <= op;
    in_entry_idx <= idx;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic random_command();
    int                 pick;
    lrutsp_pkg::op_t    op;
    lrutsp_pkg::entry_t idx;
    pick = $urandom_range(199);
    if (pick < 24)       op = lrutsp_pkg::OP_NEW_FRAME;
    else if (pick < 74)  op = lrutsp_pkg::OP_LOOKUP;
    else if (pick < 160) op = lrutsp_pkg::OP_ALLOC;
    else if (pick < 189) op = lrutsp_pkg::OP_RESOLVE;
    else if (pick < 190) op = lrutsp_pkg::OP_CLEAR;
    else                 op = lrutsp_pkg::op_t'($urandom_range(5, 7));
    // bias towards a hot set a little larger than the pool to mix hits and evictions
    if ($urandom_range(1) == 0) idx = lrutsp_pkg::entry_t'($urandom_range(63));
    else                        idx = lrutsp_pkg::entry_t'($urandom_range(39));
    issue(op, idx);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 26;
    issue(lrutsp_pkg::OP_LOOKUP,    6'd0);   // miss on an empty pool
    issue(lrutsp_pkg::OP_RESOLVE,   6'd5);   // resolve an unmapped entry
    issue(lrutsp_pkg::OP_ALLOC,     6'd0);
    issue(lrutsp_pkg::OP_ALLOC,     6'd63);
    issue(lrutsp_pkg::OP_LOOKUP,    6'd63);
    issue(lrutsp_pkg::OP_RESOLVE,   6'd63);
    issue(lrutsp_pkg::OP_LOOKUP,    6'd63);
    issue(lrutsp_pkg::OP_ALLOC,     6'd63);  // allocate on a mapped entry is a plain hit
    issue(lrutsp_pkg::OP_NEW_FRAME, 6'd0);
    issue(lrutsp_pkg::OP_LOOKUP,    6'd0);
    issue(lrutsp_pkg::op_t'(5),     6'd42);
    issue(lrutsp_pkg::op_t'(6),     6'd21);
    issue(lrutsp_pkg::op_t'(7),     6'd63);
    issue(lrutsp_pkg::OP_ALLOC,     6'd42);
    issue(lrutsp_pkg::OP_ALLOC,     6'd21);
    issue(lrutsp_pkg::OP_CLEAR,     6'd0);
    issue(lrutsp_pkg::OP_LOOKUP,    6'd63);
    issue(lrutsp_pkg::OP_ALLOC,     6'd21);
    issue(lrutsp_pkg::OP_NEW_FRAME, 6'd63);
    // fill the pool in one frame, then evict on a tie
    for (int i = 30; i < 30 + NUM_SLOTS; i++)
      issue(lrutsp_pkg::OP_ALLOC, lrutsp_pkg::entry_t'(i));
    issue(lrutsp_pkg::OP_ALLOC, 6'd1);

    idle_pct = 26;
    repeat (PHASE_ITEMS) random_command();
    idle_pct = 74;
    repeat (PHASE_ITEMS) random_command();
    idle_pct = 0;
    repeat (PHASE_ITEMS) random_command();

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (NUM_SLOTS + 8) @(posedge clk);

    $display("run: %0d commands over three idle profiles, %0d results compared",
             sent, checked);
    $display("run: %0d hits and %0d evictions seen", hits, evictions);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
